>>> rtl/gfbl_pkg.sv
// Shared types, constants and handshake structs for the grouped free-block list.
`default_nettype none

package gfbl_pkg;

	localparam int GROUP_WORDS = 64;
	localparam int NUM_BLOCKS  = 4096;
	localparam int ID_W        = 12;
	localparam int CNT_W       = 13;
	localparam int GW_W        = $clog2(GROUP_WORDS);
	localparam int HC_W        = $clog2(GROUP_WORDS + 1);
	localparam int STORE_AW    = ID_W + GW_W;
	localparam int STORE_DEPTH = NUM_BLOCKS * GROUP_WORDS;

	localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = CNT_W'(NUM_BLOCKS);
	localparam logic [HC_W-1:0]  HC_FULL         = HC_W'(GROUP_WORDS);
	localparam logic [HC_W-1:0]  HC_ONE          = HC_W'(1);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BAD_ID = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SPILL,
		S_RELOAD,
		S_HOLD
	} state_t;

	// Source of the block number carried by a result.
	typedef enum logic [1:0] {
		BLK_NONE,
		BLK_LIVE,
		BLK_SAVED
	} blk_sel_t;

	typedef struct packed {
		logic            operation;
		logic [ID_W-1:0] block_id;
	} item_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] alloc_block;
	} result_t;

	typedef struct packed {
		logic     accept;
		logic     push;
		logic     pop;
		logic     cnt_clr;
		logic     spill;
		logic     reload;
		logic     done_spill;
		logic     done_reload;
		logic     res_set;
		logic     res_load;
		logic     res_from_pend;
		status_t  res_code;
		blk_sel_t res_blk;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_free;
		logic id_bad;
		logic hc_full;
		logic hc_one;
		logic top_zero;
		logic cnt_done;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/gfbl_ctrl.sv
// Controller state machine for the grouped free-block list.
`default_nettype none

module gfbl_ctrl
	import gfbl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  ctl
);

	state_t   state_q;
	state_t   state_nx;
	logic     fin;
	status_t  fin_code;
	blk_sel_t fin_blk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		ctl       = '0;
		cmd_stall = 1'b1;
		fin       = 1'b0;
		fin_code  = ST_OK;
		fin_blk   = BLK_NONE;

		case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctl.accept = 1'b1;
					state_nx   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.is_free) begin
					if (stat.id_bad) begin
						fin      = 1'b1;
						fin_code = ST_BAD_ID;
					end else if (stat.hc_full) begin
						ctl.cnt_clr = 1'b1;
						state_nx    = S_SPILL;
					end else begin
						ctl.push = 1'b1;
						fin      = 1'b1;
					end
				end else if (stat.top_zero) begin
					fin      = 1'b1;
					fin_code = ST_EMPTY;
				end else if (stat.hc_one) begin
					ctl.cnt_clr = 1'b1;
					state_nx    = S_RELOAD;
				end else begin
					ctl.pop = 1'b1;
					fin     = 1'b1;
					fin_blk = BLK_LIVE;
				end
			end
			S_SPILL: begin
				ctl.spill = 1'b1;
				if (stat.cnt_done) begin
					ctl.done_spill = 1'b1;
					fin            = 1'b1;
				end
			end
			S_RELOAD: begin
				ctl.reload = 1'b1;
				if (stat.cnt_done) begin
					ctl.done_reload = 1'b1;
					fin             = 1'b1;
					fin_blk         = BLK_SAVED;
				end
			end
			S_HOLD: begin
				if (stat.out_free) begin
					ctl.res_load      = 1'b1;
					ctl.res_from_pend = 1'b1;
					state_nx          = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase

		// A finished request goes straight to the output register when it is free.
		if (fin) begin
			ctl.res_set  = 1'b1;
			ctl.res_code = fin_code;
			ctl.res_blk  = fin_blk;
			if (stat.out_free) begin
				ctl.res_load = 1'b1;
				state_nx     = S_IDLE;
			end else begin
				state_nx = S_HOLD;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/gfbl_dp.sv
// Datapath of the grouped free-block list: head stack, group store, count and output register.
`default_nettype none

module gfbl_dp
	import gfbl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            cmd,
	input  logic             cfg_valid,
	input  logic [CNT_W-1:0] cfg_data,
	output result_t          res,
	output logic             res_valid,
	input  logic             res_stall,
	input  ctrl_cmd_t        ctl,
	output dp_stat_t         stat
);

	logic [ID_W-1:0] head_mem [GROUP_WORDS];
	logic [ID_W-1:0] store_mem [STORE_DEPTH];

	logic             op_q;
	logic [ID_W-1:0]  id_q;
	logic [CNT_W-1:0] block_count_q;
	logic [HC_W-1:0]  hc_q;
	logic [HC_W-1:0]  cnt_q;
	logic [ID_W-1:0]  top_q;
	logic             head0_vld_q;
	logic             rd_zero_q;
	logic [ID_W-1:0]  head_rd_q;
	logic [ID_W-1:0]  store_rd_q;
	result_t          pend_q;
	result_t          res_q;
	logic             res_valid_q;

	logic [HC_W-1:0]     hc_dec;
	logic [HC_W-1:0]     cnt_dec;
	logic [GW_W-1:0]     head_raddr;
	logic                head_we;
	logic [GW_W-1:0]     head_waddr;
	logic [ID_W-1:0]     head_wdata;
	logic                store_we;
	logic [STORE_AW-1:0] store_waddr;
	logic [STORE_AW-1:0] store_raddr;
	logic [ID_W-1:0]     top_live;
	logic [ID_W-1:0]     res_blk;
	result_t             fresh;

	assign hc_dec  = hc_q - HC_W'(1);
	assign cnt_dec = cnt_q - HC_W'(1);

	assign head_raddr = ctl.spill ? cnt_q[GW_W-1:0] : hc_dec[GW_W-1:0];

	// Entry zero reads as 0 until it has been written once.
	assign top_live = (rd_zero_q && !head0_vld_q) ? '0 : head_rd_q;

	always_comb begin
		head_we    = 1'b0;
		head_waddr = hc_q[GW_W-1:0];
		head_wdata = id_q;
		if (ctl.push) begin
			head_we = 1'b1;
		end else if (ctl.done_spill) begin
			head_we    = 1'b1;
			head_waddr = '0;
		end else if (ctl.reload && (cnt_q != '0)) begin
			head_we    = 1'b1;
			head_waddr = cnt_dec[GW_W-1:0];
			head_wdata = store_rd_q;
		end
	end

	assign store_we    = ctl.spill && (cnt_q != '0);
	assign store_waddr = {id_q, cnt_dec[GW_W-1:0]};
	assign store_raddr = {top_q, cnt_q[GW_W-1:0]};

	always_ff @(posedge clk) begin
		head_rd_q <= head_mem[head_raddr];
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
	end

	always_ff @(posedge clk) begin
		store_rd_q <= store_mem[store_raddr];
		if (store_we) begin
			store_mem[store_waddr] <= top_live;
		end
	end

	always_comb begin
		case (ctl.res_blk)
			BLK_LIVE:  res_blk = top_live;
			BLK_SAVED: res_blk = top_q;
			default:   res_blk = '0;
		endcase
		fresh.status      = ctl.res_code;
		fresh.alloc_block = res_blk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLOCK_COUNT_RST;
			hc_q          <= HC_ONE;
			cnt_q         <= '0;
			head0_vld_q   <= 1'b0;
			rd_zero_q     <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				block_count_q <= cfg_data;
			end
			if (ctl.push) begin
				hc_q <= hc_q + HC_W'(1);
			end else if (ctl.pop) begin
				hc_q <= hc_dec;
			end else if (ctl.done_spill) begin
				hc_q <= HC_ONE;
			end else if (ctl.done_reload) begin
				hc_q <= HC_FULL;
			end
			if (ctl.cnt_clr) begin
				cnt_q <= '0;
			end else if ((ctl.spill || ctl.reload) && !stat.cnt_done) begin
				cnt_q <= cnt_q + HC_W'(1);
			end
			if (head_we && (head_waddr == '0)) begin
				head0_vld_q <= 1'b1;
			end
			rd_zero_q <= (head_raddr == '0);
			if (ctl.res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			op_q <= cmd.operation;
			id_q <= cmd.block_id;
		end
		if (ctl.cnt_clr) begin
			top_q <= top_live;
		end
		if (ctl.res_set) begin
			pend_q <= fresh;
		end
		if (ctl.res_load) begin
			res_q <= ctl.res_from_pend ? pend_q : fresh;
		end
	end

	// Ids are 12 bits wide and are checked against the configured volume size limit.
	assign stat.is_free  = (op_q == OP_FREE);
	assign stat.id_bad   = ({1'b0, id_q} >= block_count_q);
	assign stat.hc_full  = (hc_q == HC_FULL);
	assign stat.hc_one   = (hc_q == HC_ONE);
	assign stat.top_zero = (top_live == '0);
	assign stat.cnt_done = (cnt_q == HC_FULL);
	assign stat.out_free = !res_valid_q || !res_stall;

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

>>> rtl/grouped_free_block_list.sv
// Top level of the grouped free-block list allocator.
//
//   channel | signals                    | direction | carries
//   cmd     | cmd_valid, cmd_stall, cmd  | in        | operation, block_id
//   res     | res_valid, res_stall, res  | out       | status, alloc_block
//   cfg     | cfg_valid, cfg_ready, cfg_data | in    | block_count
//
// A plain push or pop accepts the request and reads the top of the head stack,
// then updates it and produces the result.
// A spill or reload copies a whole group between the head and store memories
// one word a cycle.
// Reset clears the count to one and marks head entry zero as holding 0.
// The next request is accepted while a result waits in the output register.
`default_nettype none

module grouped_free_block_list
	import gfbl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  item_t            cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output result_t          res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	gfbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	gfbl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.ctl       (ctl),
		.stat      (stat)
	);

endmodule

`default_nettype wire

>>> rtl/gfbl_checker.sv
// Port-level checks for the grouped free-block list and their bind to the top level.
`default_nettype none

module gfbl_checker
	import gfbl_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             cmd_valid,
	input wire logic             cmd_stall,
	input wire item_t            cmd,
	input wire logic             res_valid,
	input wire logic             res_stall,
	input wire result_t          res,
	input wire logic             cfg_valid,
	input wire logic             cfg_ready,
	input wire logic [CNT_W-1:0] cfg_data
);

	// A stalled result stays put.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// A stalled request stays put.
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
		else $error("stalled request changed");

	// Every request passes through the execute state, so none is taken right after another.
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("request accepted in the cycle after another");

	// Failed requests never return a block number.
	a_fail_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != ST_OK) |-> res.alloc_block == '0)
		else $error("failed request returned a block");

	// Configuration writes are always taken and carry known data.
	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready && !$isunknown(cfg_data))
		else $error("configuration write refused or unknown");

endmodule

bind grouped_free_block_list gfbl_checker u_gfbl_checker (.*);

`default_nettype wire
